// ===== rtl/core/fdtp_pkg.sv =====
// Shared types and constants for the device-tree structure token parser.
package fdtp_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned DEPTH_W   = 6;
   localparam int unsigned MAX_DEPTH = 63;
   localparam int unsigned LEFT_W    = 31;

   // Structure-block token codes
   localparam logic [WORD_W-1:0] TOK_BEGIN_NODE = 32'd1;
   localparam logic [WORD_W-1:0] TOK_END_NODE   = 32'd2;
   localparam logic [WORD_W-1:0] TOK_PROP       = 32'd3;
   localparam logic [WORD_W-1:0] TOK_NOP        = 32'd4;
   localparam logic [WORD_W-1:0] TOK_END        = 32'd9;

   typedef enum logic [2:0] {
      KIND_BEGIN = 3'd0,
      KIND_ENDN  = 3'd1,
      KIND_PROP  = 3'd2,
      KIND_NOP   = 3'd3,
      KIND_END   = 3'd4,
      KIND_NAMEW = 3'd5,
      KIND_DATAW = 3'd6,
      KIND_ERR   = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      PH_TOKEN = 3'd0,
      PH_NAME  = 3'd1,
      PH_PLEN  = 3'd2,
      PH_POFF  = 3'd3,
      PH_DATA  = 3'd4,
      PH_ERROR = 3'd5
   } phase_type;

   typedef struct packed {
      kind_type             kind;
      logic [WORD_W-1:0]    value;
      logic [WORD_W-1:0]    prop_length;
      logic [DEPTH_W-1:0]   depth;
      logic                 last;
   } result_type;

endpackage

// ===== rtl/core/fdtp_parser.sv =====
// Token parser state machine: consumes one word per request, yields at most one result.
module fdtp_parser
   import fdtp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [WORD_W-1:0] csr_wr_data,
   input  logic              take,
   input  logic [WORD_W-1:0] word,
   output logic              res_valid,
   output result_type        res
);

   localparam logic [DEPTH_W-1:0] DepthMax = DEPTH_W'(MAX_DEPTH);
   localparam logic [WORD_W-1:0]  PosSat   = {WORD_W{1'b1}};

   phase_type           phase_ff, phase_in;
   logic [WORD_W-1:0]   struct_bytes_ff;
   logic [WORD_W-1:0]   pos_ff, pos_in;
   logic [LEFT_W-1:0]   left_ff, left_in;
   logic [WORD_W-1:0]   len_ff, len_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;

   logic                at_limit;
   logic                active;
   logic                zero_byte;
   logic [LEFT_W-1:0]   words_needed;

   assign at_limit  = (phase_ff == PH_TOKEN) && (pos_ff >= struct_bytes_ff);
   assign active    = take && (phase_ff != PH_ERROR) && !at_limit;
   assign zero_byte = (word[31:24] == 8'd0) || (word[23:16] == 8'd0) ||
                      (word[15:8] == 8'd0) || (word[7:0] == 8'd0);
   assign words_needed = {1'b0, len_ff[WORD_W-1:2]} + LEFT_W'(|len_ff[1:0]);

   // Next state
   always_comb begin
      phase_in = phase_ff;
      if (active) begin
         unique case (phase_ff)
            PH_TOKEN: begin
               if (word == TOK_BEGIN_NODE) begin
                  phase_in = PH_NAME;
               end else if (word == TOK_PROP) begin
                  phase_in = PH_PLEN;
               end else if (word == TOK_END_NODE || word == TOK_NOP || word == TOK_END) begin
                  phase_in = PH_TOKEN;
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            PH_NAME: begin
               if (zero_byte) phase_in = PH_TOKEN;
            end
            PH_PLEN:  phase_in = PH_POFF;
            PH_POFF:  phase_in = (words_needed == '0) ? PH_TOKEN : PH_DATA;
            PH_DATA: begin
               if (left_ff <= LEFT_W'(1)) phase_in = PH_TOKEN;
            end
            PH_ERROR: phase_in = PH_ERROR;
            default:  phase_in = PH_ERROR;
         endcase
      end
   end

   // Datapath and result
   always_comb begin
      pos_in          = pos_ff;
      left_in         = left_ff;
      len_in          = len_ff;
      depth_in        = depth_ff;
      res_valid       = 1'b0;
      res.kind        = KIND_NOP;
      res.value       = '0;
      res.prop_length = '0;
      res.last        = 1'b0;
      if (active) begin
         pos_in = (pos_ff > (PosSat - WORD_W'(4))) ? PosSat : pos_ff + WORD_W'(4);
         unique case (phase_ff)
            PH_TOKEN: begin
               res_valid = (word != TOK_PROP);
               if (word == TOK_BEGIN_NODE) begin
                  if (depth_ff < DepthMax) depth_in = depth_ff + DEPTH_W'(1);
                  res.kind = KIND_BEGIN;
               end else if (word == TOK_END_NODE) begin
                  if (depth_ff != '0) depth_in = depth_ff - DEPTH_W'(1);
                  res.kind = KIND_ENDN;
               end else if (word == TOK_NOP) begin
                  res.kind = KIND_NOP;
               end else if (word == TOK_END) begin
                  res.kind = KIND_END;
               end else if (word != TOK_PROP) begin
                  res.kind  = KIND_ERR;
                  res.value = word;
               end
            end
            PH_NAME: begin
               res_valid = 1'b1;
               res.kind  = KIND_NAMEW;
               res.value = word;
               res.last  = zero_byte;
            end
            PH_PLEN: len_in = word;
            PH_POFF: begin
               left_in         = words_needed;
               res_valid       = 1'b1;
               res.kind        = KIND_PROP;
               res.value       = word;
               res.prop_length = len_ff;
            end
            PH_DATA: begin
               res_valid = 1'b1;
               res.kind  = KIND_DATAW;
               res.value = word;
               if (left_ff <= LEFT_W'(1)) begin
                  left_in  = '0;
                  res.last = 1'b1;
               end else begin
                  left_in = left_ff - LEFT_W'(1);
               end
            end
            PH_ERROR: res_valid = 1'b0;
            default:  res_valid = 1'b0;
         endcase
      end
      res.depth = depth_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_TOKEN;
         struct_bytes_ff <= '0;
         pos_ff          <= '0;
         left_ff         <= '0;
         len_ff          <= '0;
         depth_ff        <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         left_ff  <= left_in;
         len_ff   <= len_in;
         depth_ff <= depth_in;
         if (csr_wr_en) struct_bytes_ff <= csr_wr_data;
      end
   end

endmodule

// ===== rtl/core/fdtp_skid.sv =====
// Two-entry result buffer: output register plus skid stage.
module fdtp_skid
   import fdtp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       space,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       head_vld_ff, tail_vld_ff;
   result_type head_ff, tail_ff;
   logic       pop;

   assign pop       = head_vld_ff && out_ready;
   assign space     = !tail_vld_ff;
   assign out_valid = head_vld_ff;
   assign out_data  = head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= 1'b0;
         tail_vld_ff <= 1'b0;
      end else begin
         if (pop) begin
            if (tail_vld_ff) begin
               head_ff     <= tail_ff;
               head_vld_ff <= 1'b1;
               tail_vld_ff <= push;
               if (push) tail_ff <= push_data;
            end else begin
               head_vld_ff <= push;
               if (push) head_ff <= push_data;
            end
         end else if (push) begin
            if (!head_vld_ff) begin
               head_ff     <= push_data;
               head_vld_ff <= 1'b1;
            end else begin
               tail_ff     <= push_data;
               tail_vld_ff <= 1'b1;
            end
         end
      end
   end

endmodule

// ===== rtl/core/fdt_structure_token_parser_core.sv =====
// Top level of the device-tree structure token parser.
//  channel | direction | ports
//  req     | in        | req_valid, req_ready, req_word
//  rsp     | out       | rsp_valid, rsp_ready, rsp_kind/value/prop_length/depth/last
//  csr     | in        | csr_wr_en, csr_wr_data (structure block size in bytes)
// One word is taken per cycle while req_ready is high; any result is registered.
// Reset is synchronous and returns the parser to the expect-token phase at byte 0.
// A two-entry result buffer keeps req_ready high while one result waits on rsp;
// req_ready drops only when both entries are full.
module fdt_structure_token_parser_core
   import fdtp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [WORD_W-1:0]  req_word,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_kind,
   output logic [WORD_W-1:0]  rsp_value,
   output logic [WORD_W-1:0]  rsp_prop_length,
   output logic [DEPTH_W-1:0] rsp_depth,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic [WORD_W-1:0]  csr_wr_data
);

   logic       take;
   logic       res_valid;
   result_type res;
   result_type head;

   assign take = req_valid && req_ready;

   fdtp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .take        (take),
      .word        (req_word),
      .res_valid   (res_valid),
      .res         (res)
   );

   fdtp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .space     (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (head)
   );

   assign rsp_kind        = head.kind;
   assign rsp_value       = head.value;
   assign rsp_prop_length = head.prop_length;
   assign rsp_depth       = head.depth;
   assign rsp_last        = head.last;

endmodule
